FILE: rtl/core/tkpc_pkg.sv
// Shared types, register indexes, reset values and event codes for the two-key classifier.
package tkpc_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned RelW     = 8;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SHORT_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COMBO      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SOLO_OTHER = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RELEASE    = 3'd4;

  // Reset values
  localparam logic [CountW-1:0] RST_SHORT_MIN  = 16'd20;
  localparam logic [CountW-1:0] RST_LONG       = 16'd500;
  localparam logic [CountW-1:0] RST_COMBO      = 16'd100;
  localparam logic [CountW-1:0] RST_SOLO_OTHER = 16'd50;
  localparam logic [RelW-1:0]   RST_RELEASE    = 8'd10;

  // Saturation limits
  localparam logic [CountW-1:0] COUNT_MAX = '1;
  localparam logic [RelW-1:0]   REL_MAX   = '1;

  // Event codes
  localparam logic [CodeW-1:0] EV_NONE       = 8'h00;
  localparam logic [CodeW-1:0] EV_ONE_SHORT  = 8'h01;
  localparam logic [CodeW-1:0] EV_ONE_LONG   = 8'h02;
  localparam logic [CodeW-1:0] EV_TWO_SHORT  = 8'h10;
  localparam logic [CodeW-1:0] EV_TWO_LONG   = 8'h20;
  localparam logic [CodeW-1:0] EV_ONE_HOLD   = 8'h03;
  localparam logic [CodeW-1:0] EV_TWO_HOLD   = 8'h30;
  localparam logic [CodeW-1:0] EV_COMBO_HOLD = 8'h44;

  typedef struct packed {
    logic [CountW-1:0] short_min_ticks;
    logic [CountW-1:0] long_ticks;
    logic [CountW-1:0] combo_ticks;
    logic [CountW-1:0] solo_other_max;
    logic [RelW-1:0]   release_ticks;
  } cfg_t;

endpackage

FILE: rtl/core/tkpc_regs.sv
// Configuration register file for the two-key classifier.
module tkpc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tkpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tkpc_pkg::CfgDataW-1:0]  cfg_data,
  output tkpc_pkg::cfg_t                 cfg
);
  import tkpc_pkg::*;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_min_ticks <= RST_SHORT_MIN;
      cfg.long_ticks      <= RST_LONG;
      cfg.combo_ticks     <= RST_COMBO;
      cfg.solo_other_max  <= RST_SOLO_OTHER;
      cfg.release_ticks   <= RST_RELEASE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHORT_MIN:  cfg.short_min_ticks <= cfg_data;
        REG_LONG:       cfg.long_ticks      <= cfg_data;
        REG_COMBO:      cfg.combo_ticks     <= cfg_data;
        REG_SOLO_OTHER: cfg.solo_other_max  <= cfg_data;
        REG_RELEASE:    cfg.release_ticks   <= cfg_data[RelW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/tkpc_core.sv
// Hold/release counters and the event decision for one tick.
module tkpc_core (
  input  logic                         clk,
  input  logic                         rst,
  input  tkpc_pkg::cfg_t               cfg,
  input  logic                         fire,
  input  logic                         tick,
  input  logic                         key_one,
  input  logic                         key_two,
  output logic [tkpc_pkg::CodeW-1:0]   code
);
  import tkpc_pkg::*;

  logic [CountW-1:0] hold_one, hold_two;
  logic [RelW-1:0]   rel_count;
  logic [CountW-1:0] hold_one_next, hold_two_next;
  logic [RelW-1:0]   rel_count_next;
  logic [CountW-1:0] hold_one_inc, hold_two_inc;
  logic [RelW-1:0]   rel_inc;
  logic [CodeW-1:0]  class_one, class_two;

  // Saturating increments
  assign hold_one_inc = (hold_one == COUNT_MAX) ? COUNT_MAX : hold_one + 1'b1;
  assign hold_two_inc = (hold_two == COUNT_MAX) ? COUNT_MAX : hold_two + 1'b1;
  assign rel_inc      = (rel_count == REL_MAX) ? REL_MAX : rel_count + 1'b1;

  // Short/long classification of the stored hold counts
  always_comb begin
    class_one = EV_NONE;
    if (hold_one > cfg.short_min_ticks && hold_one < cfg.long_ticks)
      class_one = EV_ONE_SHORT;
    else if (hold_one >= cfg.long_ticks)
      class_one = EV_ONE_LONG;
    class_two = EV_NONE;
    if (hold_two > cfg.short_min_ticks && hold_two < cfg.long_ticks)
      class_two = EV_TWO_SHORT;
    else if (hold_two >= cfg.long_ticks)
      class_two = EV_TWO_LONG;
  end

  // Next state and event code
  always_comb begin
    hold_one_next  = hold_one;
    hold_two_next  = hold_two;
    rel_count_next = rel_count;
    code           = EV_NONE;
    if (tick) begin
      if (key_one || key_two) begin
        rel_count_next = '0;
        if (key_one) hold_one_next = hold_one_inc;
        if (key_two) hold_two_next = hold_two_inc;
        if (hold_one_next == cfg.long_ticks && hold_two_next < cfg.solo_other_max)
          code = EV_ONE_HOLD;
        else if (hold_two_next == cfg.long_ticks && hold_one_next < cfg.solo_other_max)
          code = EV_TWO_HOLD;
        else if (hold_one_next == cfg.combo_ticks && hold_two_next > cfg.combo_ticks)
          code = EV_COMBO_HOLD;
        else if (hold_one_next > cfg.combo_ticks && hold_two_next == cfg.combo_ticks)
          code = EV_COMBO_HOLD;
      end else if (rel_inc < cfg.release_ticks) begin
        rel_count_next = rel_inc;
      end else begin
        rel_count_next = '0;
        hold_one_next  = '0;
        hold_two_next  = '0;
        code           = class_one + class_two;
      end
    end
  end

  // State update once per transaction leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_one  <= '0;
      hold_two  <= '0;
      rel_count <= '0;
    end else if (fire) begin
      hold_one  <= hold_one_next;
      hold_two  <= hold_two_next;
      rel_count <= rel_count_next;
    end
  end

endmodule

FILE: rtl/core/two_key_press_classifier_unit.sv
// Two-key press classifier: each transaction is one sample of a 1 ms tick and two
// key levels and yields exactly one result (event_code, send_flag). One transaction
// is taken every clock while in_stall is low; a result passes through the input
// register, then the counter update and event decision, into the result register.
// The hold and release counters advance once per transaction as it leaves the
// input register.
// Stall on the output side holds the result register and backs up into in_stall.
// Configuration writes are accepted on every cycle (cfg_ready is tied high).
module two_key_press_classifier_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           tick,
  input  logic                           key_one_level,
  input  logic                           key_two_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tkpc_pkg::CodeW-1:0]     event_code,
  output logic                           send_flag,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tkpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tkpc_pkg::CfgDataW-1:0]  cfg_data
);
  import tkpc_pkg::*;

  cfg_t             cfg;
  logic             s1_valid, s1_tick, s1_key_one, s1_key_two;
  logic             advance, fire;
  logic [CodeW-1:0] code;

  tkpc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Result register can load when empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_tick    <= tick;
      s1_key_one <= key_one_level;
      s1_key_two <= key_two_level;
    end
  end

  tkpc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .tick    (s1_tick),
    .key_one (s1_key_one),
    .key_two (s1_key_two),
    .code    (code)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_code <= code;
      send_flag  <= (code != EV_NONE);
    end
  end

endmodule

FILE: rtl/core/tkpc_checker.sv
// Port-level checks for the two-key classifier, bound to the top level.
module tkpc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [tkpc_pkg::CodeW-1:0]     event_code,
  input logic                           send_flag
);
  import tkpc_pkg::*;

  // Flag tracks a nonzero code
  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (send_flag == (event_code != EV_NONE)))
    else $error("send_flag disagrees with event_code");

  // Only defined codes are ever sent
  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_code == EV_NONE || event_code == EV_ONE_SHORT ||
                   event_code == EV_ONE_LONG || event_code == EV_TWO_SHORT ||
                   event_code == EV_TWO_LONG || event_code == (EV_ONE_SHORT | EV_TWO_SHORT) ||
                   event_code == (EV_ONE_SHORT | EV_TWO_LONG) ||
                   event_code == (EV_ONE_LONG | EV_TWO_SHORT) ||
                   event_code == (EV_ONE_LONG | EV_TWO_LONG) ||
                   event_code == EV_ONE_HOLD || event_code == EV_TWO_HOLD ||
                   event_code == EV_COMBO_HOLD))
    else $error("undefined event_code");

  // A fresh result follows an accepted input transaction
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input transaction");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_code) && $stable(send_flag))
    else $error("stalled result changed");

endmodule

bind two_key_press_classifier_unit tkpc_checker u_tkpc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .event_code (event_code),
  .send_flag  (send_flag)
);
